FILE: rtl/bpqsf_pkg.sv
// bpqsf_pkg: types, register indexes and reset values for the quiet span finder
// used by the channel interfaces, the controller, the datapath and the top level
`default_nettype none

package bpqsf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int IDX_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CONSEC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_QUIET  = 3'd4;

  localparam logic [15:0] BLOCK_LEN_RST  = 16'd1000;
  localparam logic [30:0] THRESHOLD_RST  = 31'h4000_0000;
  localparam logic [15:0] MIN_CONSEC_RST = 16'd1;
  localparam logic [15:0] PAD_RST        = 16'd0;
  localparam logic [15:0] MIN_QUIET_RST  = 16'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_MAG,
    ST_MUL_CNT,
    ST_MUL_THR,
    ST_DIFF,
    ST_DECIDE,
    ST_LENCHK,
    ST_ROUTE,
    ST_TRAIL,
    ST_MUL_START,
    ST_MUL_END,
    ST_OUT,
    ST_CLEAR
  } state_t;

  // operand selection and destination of the shared multiplier
  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_SQ_LO,
    MOP_SQ_HI,
    MOP_MAG,
    MOP_CNT,
    MOP_THR,
    MOP_START,
    MOP_END
  } mul_op_t;

  typedef struct packed {
    logic    acc;
    mul_op_t mop;
    logic    diff;
    logic    decide;
    logic    lenchk;
    logic    trail;
    logic    load;
    logic    clear;
  } cmd_t;

  typedef struct packed {
    logic blk_end;
    logic in_last;
    logic last;
    logic trail;
    logic emit;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/bpqsf_if.sv
// bpqsf_in_if and bpqsf_out_if: valid/ready channels of the quiet span finder
// depends on bpqsf_pkg for field widths
`default_nettype none

interface bpqsf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bpqsf_pkg::SAMPLE_W-1:0] sample;
  logic                                  last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface bpqsf_out_if;
  logic                          valid;
  logic                          ready;
  logic [bpqsf_pkg::IDX_W-1:0]   start_sample;
  logic [bpqsf_pkg::IDX_W-1:0]   end_sample;

  modport source (output valid, output start_sample, output end_sample, input ready);
  modport sink   (input valid, input start_sample, input end_sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/bpqsf_ctrl.sv
// bpqsf_ctrl: sequencer for block-end evaluation, span reporting and end-of-signal clear
// depends on bpqsf_pkg; drives the datapath by cmd_t and reads status_t
`default_nettype none

module bpqsf_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  bpqsf_pkg::status_t   st,
  output bpqsf_pkg::cmd_t      cmd
);

  bpqsf_pkg::state_t state_r, state_nxt;
  logic              out_valid_r;
  logic              load_ok;

  assign load_ok   = !out_valid_r || out_ready;
  assign in_ready  = (state_r == bpqsf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpqsf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      bpqsf_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (st.blk_end) begin
            state_nxt = bpqsf_pkg::ST_MUL_LO;
          end else if (st.in_last) begin
            state_nxt = bpqsf_pkg::ST_TRAIL;
          end
        end
      end
      bpqsf_pkg::ST_MUL_LO: begin
        cmd.mop   = bpqsf_pkg::MOP_SQ_LO;
        state_nxt = bpqsf_pkg::ST_MUL_HI;
      end
      bpqsf_pkg::ST_MUL_HI: begin
        cmd.mop   = bpqsf_pkg::MOP_SQ_HI;
        state_nxt = bpqsf_pkg::ST_MUL_MAG;
      end
      bpqsf_pkg::ST_MUL_MAG: begin
        cmd.mop   = bpqsf_pkg::MOP_MAG;
        state_nxt = bpqsf_pkg::ST_MUL_CNT;
      end
      bpqsf_pkg::ST_MUL_CNT: begin
        cmd.mop   = bpqsf_pkg::MOP_CNT;
        state_nxt = bpqsf_pkg::ST_MUL_THR;
      end
      bpqsf_pkg::ST_MUL_THR: begin
        cmd.mop   = bpqsf_pkg::MOP_THR;
        state_nxt = bpqsf_pkg::ST_DIFF;
      end
      bpqsf_pkg::ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = bpqsf_pkg::ST_DECIDE;
      end
      bpqsf_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = bpqsf_pkg::ST_LENCHK;
      end
      bpqsf_pkg::ST_LENCHK: begin
        cmd.lenchk = 1'b1;
        state_nxt  = bpqsf_pkg::ST_ROUTE;
      end
      bpqsf_pkg::ST_ROUTE: begin
        priority if (st.emit) begin
          state_nxt = bpqsf_pkg::ST_MUL_START;
        end else if (st.last && !st.trail) begin
          state_nxt = bpqsf_pkg::ST_TRAIL;
        end else if (st.last) begin
          state_nxt = bpqsf_pkg::ST_CLEAR;
        end else begin
          state_nxt = bpqsf_pkg::ST_IDLE;
        end
      end
      bpqsf_pkg::ST_TRAIL: begin
        cmd.trail = 1'b1;
        state_nxt = bpqsf_pkg::ST_LENCHK;
      end
      bpqsf_pkg::ST_MUL_START: begin
        cmd.mop   = bpqsf_pkg::MOP_START;
        state_nxt = bpqsf_pkg::ST_MUL_END;
      end
      bpqsf_pkg::ST_MUL_END: begin
        cmd.mop   = bpqsf_pkg::MOP_END;
        state_nxt = bpqsf_pkg::ST_OUT;
      end
      bpqsf_pkg::ST_OUT: begin
        // wait for the output register to free up
        if (load_ok) begin
          cmd.load  = 1'b1;
          state_nxt = st.last ? bpqsf_pkg::ST_CLEAR : bpqsf_pkg::ST_IDLE;
        end
      end
      bpqsf_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = bpqsf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bpqsf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/bpqsf_dp.sv
// bpqsf_dp: accumulators, configuration registers, shared 32x32 multiplier,
// loudness test, span bookkeeping and result register; depends on bpqsf_pkg
`default_nettype none

module bpqsf_dp (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire  [bpqsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [bpqsf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire  signed [bpqsf_pkg::SAMPLE_W-1:0] in_sample,
  input  wire                                   in_last,
  input  bpqsf_pkg::cmd_t                       cmd,
  output bpqsf_pkg::status_t                    st,
  output logic [bpqsf_pkg::IDX_W-1:0]           out_start_sample,
  output logic [bpqsf_pkg::IDX_W-1:0]           out_end_sample
);

  // configuration
  logic [15:0] block_len_r;
  logic [30:0] thr_r;
  logic [15:0] min_consec_r;
  logic [15:0] pad_r;
  logic [15:0] min_quiet_r;
  logic [15:0] len_eff;

  // running state
  logic [15:0] pos_r;
  logic [31:0] sum_r;
  logic [46:0] sq_r;
  logic [31:0] bd_r;
  logic [31:0] lr_r;
  logic        in_noise_r;
  logic [32:0] qb_r;
  logic        last_r;
  logic        trail_r;
  logic        cand_r;
  logic        emit_r;

  // block-end working registers
  logic [31:0]        mag_r;
  logic [62:0]        lhs_r;
  logic [61:0]        s2_r;
  logic [31:0]        c2_r;
  logic [62:0]        rhs_r;
  logic [62:0]        diff_r;
  logic signed [33:0] b0_r;
  logic signed [33:0] b1_r;
  logic signed [33:0] e_r;
  logic [31:0]        start_r;
  logic [31:0]        end_r;

  logic signed [31:0] smp_sq;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic               loud;
  logic               trig;
  logic [31:0]        lr_inc;
  logic [31:0]        bd_inc;
  logic signed [33:0] b1_loud;
  logic signed [33:0] b1_trail;
  logic signed [33:0] bd_s;
  logic signed [33:0] e_nxt;
  logic [32:0]        qb_quiet;
  logic signed [34:0] span;
  logic               span_ok;

  // block index to sample index, negative clipped to zero, overflow saturated
  function automatic logic [31:0] to_idx(input logic signed [33:0] blk,
                                         input logic [63:0] prod);
    logic [31:0] res;
    if (blk[33] || (blk == '0)) begin
      res = '0;
    end else if ((blk[33:32] != 2'b00) || (prod[47:32] != '0)) begin
      res = '1;
    end else begin
      res = prod[31:0];
    end
    return res;
  endfunction

  assign len_eff = (block_len_r == '0) ? 16'd1 : block_len_r;
  assign smp_sq  = in_sample * in_sample;

  assign st.blk_end = ({1'b0, pos_r} + 17'd1) >= {1'b0, len_eff};
  assign st.in_last = in_last;
  assign st.last    = last_r;
  assign st.trail   = trail_r;
  assign st.emit    = emit_r;

  // shared multiplier
  always_comb begin
    unique case (cmd.mop)
      bpqsf_pkg::MOP_SQ_LO: begin
        mul_a = {16'd0, pos_r};
        mul_b = sq_r[31:0];
      end
      bpqsf_pkg::MOP_SQ_HI: begin
        mul_a = {16'd0, pos_r};
        mul_b = {17'd0, sq_r[46:32]};
      end
      bpqsf_pkg::MOP_MAG: begin
        mul_a = mag_r;
        mul_b = mag_r;
      end
      bpqsf_pkg::MOP_CNT: begin
        mul_a = {16'd0, pos_r};
        mul_b = {16'd0, pos_r};
      end
      bpqsf_pkg::MOP_THR: begin
        mul_a = {1'b0, thr_r};
        mul_b = c2_r;
      end
      bpqsf_pkg::MOP_START: begin
        mul_a = b0_r[31:0];
        mul_b = {16'd0, len_eff};
      end
      bpqsf_pkg::MOP_END: begin
        mul_a = e_r[31:0];
        mul_b = {16'd0, len_eff};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // block decision and span arithmetic
  assign loud     = diff_r >= rhs_r;
  assign lr_inc   = (lr_r == '1) ? lr_r : lr_r + 32'd1;
  assign bd_inc   = (bd_r == '1) ? bd_r : bd_r + 32'd1;
  assign trig     = loud && (lr_inc == {16'd0, min_consec_r}) && !in_noise_r;
  assign bd_s     = $signed({2'b00, bd_r});
  assign b1_loud  = bd_s - $signed({2'b00, lr_inc}) + 34'sd1 - $signed({18'd0, pad_r});
  assign b1_trail = bd_s - ((lr_r != '0) ?
                            ($signed({2'b00, lr_r}) + $signed({18'd0, pad_r})) : 34'sd0);
  assign qb_quiet = {1'b0, bd_r} + {17'd0, pad_r};
  assign span     = $signed({b1_r[33], b1_r}) - $signed({b0_r[33], b0_r});
  assign span_ok  = span >= $signed({19'd0, min_quiet_r});
  assign e_nxt    = (b1_r < bd_s) ? b1_r : bd_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_len_r  <= bpqsf_pkg::BLOCK_LEN_RST;
      thr_r        <= bpqsf_pkg::THRESHOLD_RST;
      min_consec_r <= bpqsf_pkg::MIN_CONSEC_RST;
      pad_r        <= bpqsf_pkg::PAD_RST;
      min_quiet_r  <= bpqsf_pkg::MIN_QUIET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpqsf_pkg::REG_BLOCK_LEN:  block_len_r  <= cfg_data[15:0];
        bpqsf_pkg::REG_THRESHOLD:  thr_r        <= cfg_data;
        bpqsf_pkg::REG_MIN_CONSEC: min_consec_r <= cfg_data[15:0];
        bpqsf_pkg::REG_PAD:        pad_r        <= cfg_data[15:0];
        bpqsf_pkg::REG_MIN_QUIET:  min_quiet_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      pos_r      <= '0;
      sum_r      <= '0;
      sq_r       <= '0;
      bd_r       <= '0;
      lr_r       <= '0;
      in_noise_r <= 1'b0;
      qb_r       <= '0;
      last_r     <= 1'b0;
      trail_r    <= 1'b0;
      cand_r     <= 1'b0;
      emit_r     <= 1'b0;
    end else begin
      if (cmd.acc) begin
        pos_r  <= pos_r + 16'd1;
        sum_r  <= sum_r + {{16{in_sample[15]}}, in_sample};
        sq_r   <= sq_r + {16'd0, smp_sq[30:0]};
        last_r <= in_last;
      end
      if (cmd.decide) begin
        pos_r <= '0;
        sum_r <= '0;
        sq_r  <= '0;
        bd_r  <= bd_inc;
        if (loud) begin
          lr_r   <= lr_inc;
          cand_r <= trig;
          if (trig) begin
            in_noise_r <= 1'b1;
          end
        end else begin
          if (in_noise_r) begin
            qb_r <= qb_quiet;
          end
          lr_r       <= '0;
          in_noise_r <= 1'b0;
          cand_r     <= 1'b0;
        end
      end
      if (cmd.trail) begin
        cand_r  <= !in_noise_r;
        trail_r <= 1'b1;
      end
      if (cmd.lenchk) begin
        emit_r <= cand_r && span_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.mop)
      bpqsf_pkg::MOP_SQ_LO: begin
        lhs_r <= {15'd0, mul_p[47:0]};
        mag_r <= sum_r[31] ? (~sum_r + 32'd1) : sum_r;
      end
      bpqsf_pkg::MOP_SQ_HI: lhs_r   <= lhs_r + {mul_p[30:0], 32'd0};
      bpqsf_pkg::MOP_MAG:   s2_r    <= mul_p[61:0];
      bpqsf_pkg::MOP_CNT:   c2_r    <= mul_p[31:0];
      bpqsf_pkg::MOP_THR:   rhs_r   <= mul_p[62:0];
      bpqsf_pkg::MOP_START: start_r <= to_idx(b0_r, mul_p);
      bpqsf_pkg::MOP_END:   end_r   <= to_idx(e_r, mul_p);
      default: ;
    endcase
    if (cmd.diff) begin
      // dc-removed energy, floored at zero
      diff_r <= (lhs_r >= {1'b0, s2_r}) ? (lhs_r - {1'b0, s2_r}) : '0;
    end
    if (cmd.decide) begin
      b0_r <= $signed({1'b0, qb_r});
      b1_r <= b1_loud;
    end
    if (cmd.trail) begin
      b0_r <= $signed({1'b0, qb_r});
      b1_r <= b1_trail;
    end
    if (cmd.lenchk) begin
      e_r <= e_nxt;
    end
    if (cmd.load) begin
      out_start_sample <= start_r;
      out_end_sample   <= end_r;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/block_power_quiet_span_finder_unit.sv
// Quiet span finder over block power of a 16-bit audio stream.
// Depends on bpqsf_pkg, bpqsf_if (channels), bpqsf_ctrl and bpqsf_dp.
//
// in_chan carries one signed sample per item, with last marking the final
// sample of the signal. out_chan carries one quiet span per item as start and
// exclusive end sample index. Registers are written on cfg_we, index cfg_index,
// data cfg_data; the user writes them only while no item is in flight, and the
// block itself does not enforce it. Samples that do not close a block stream
// at one per clock. A sample that closes a block holds in_chan.ready low while
// the single 32x32 multiplier works through the block energy terms and the
// decision; the report states follow when a span is reported, and the span
// appears on out_chan the cycle after ST_OUT loads it. A last sample adds the
// trailing span check, and reports from it, unless its final block reported a
// span; then it clears, and the block starts a new signal.
// The result sits in an output register: input items are still taken while it
// waits, and only a new span to report waits for out_chan.ready.
// Synchronous reset clears the counters and accumulators and loads the
// register defaults; a partial block at the last sample is dropped.
`default_nettype none

module block_power_quiet_span_finder_unit (
  input  wire                                clk,
  input  wire                                rst_n,
  bpqsf_in_if.sink                           in_chan,
  bpqsf_out_if.source                        out_chan,
  input  wire                                cfg_we,
  input  wire  [bpqsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [bpqsf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  bpqsf_pkg::cmd_t    cmd;
  bpqsf_pkg::status_t st;
  logic               in_ready;
  logic               out_valid;

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  bpqsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .st        (st),
    .cmd       (cmd)
  );

  bpqsf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_sample        (in_chan.sample),
    .in_last          (in_chan.last),
    .cmd              (cmd),
    .st               (st),
    .out_start_sample (out_chan.start_sample),
    .out_end_sample   (out_chan.end_sample)
  );

endmodule

`default_nettype wire

FILE: rtl/bpqsf_checker.sv
// bpqsf_checker: port-level assertions for the quiet span finder, bound to the top level
// depends on bpqsf_pkg for widths
`default_nettype none

module bpqsf_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          in_last,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [bpqsf_pkg::IDX_W-1:0]   out_start,
  input wire [bpqsf_pkg::IDX_W-1:0]   out_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_start) && $stable(out_end))
    else $error("result item changed while stalled");

  // end of signal is followed by the trailing check or a span report, then the clear state
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("item taken right after last sample");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind block_power_quiet_span_finder_unit bpqsf_checker u_bpqsf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_last   (in_chan.last),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_start (out_chan.start_sample),
  .out_end   (out_chan.end_sample)
);

`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking bench for block_power_quiet_span_finder_unit, a quiet span finder
// over block power. It predicts each reported span from the accepted samples and checks
// out_chan against it. Depends on bpqsf_pkg, bpqsf_if and the rtl top level.

module tb;

  localparam int          SETTLE_CYCLES = 40;
  localparam longint      RUN_LIMIT     = 100_000_000;
  localparam logic [bpqsf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [bpqsf_pkg::IDX_W-1:0] start_sample;
    logic [bpqsf_pkg::IDX_W-1:0] end_sample;
  } span_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                             cfg_we;
  logic [bpqsf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bpqsf_pkg::CFG_DATA_W-1:0] cfg_data;

  bpqsf_in_if  in_ch ();
  bpqsf_out_if out_ch ();

  block_power_quiet_span_finder_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register copies
  logic [15:0] cfg_len;
  logic [30:0] cfg_thr;
  logic [15:0] cfg_min_consec;
  logic [15:0] cfg_pad;
  logic [15:0] cfg_min_quiet;

  // tracked block state
  int unsigned     blk_fill;
  longint          blk_sum;
  longint unsigned blk_energy;
  int unsigned     blk_count;
  int unsigned     loud_len;
  bit              noisy;
  longint          quiet_from;

  span_t pending_spans[$];
  int    n_err;
  int    n_sent;
  int    tx_gap_max;
  int    rx_gap_max;
  int    rx_hold_cycles;

  function automatic void clear_tracking();
    blk_fill   = 0;
    blk_sum    = 0;
    blk_energy = 0;
    blk_count  = 0;
    loud_len   = 0;
    noisy      = 1'b0;
    quiet_from = 0;
  endfunction

  function automatic void apply_reg(logic [bpqsf_pkg::CFG_IDX_W-1:0] idx,
                                    logic [bpqsf_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      bpqsf_pkg::REG_BLOCK_LEN:  cfg_len        = val[15:0];
      bpqsf_pkg::REG_THRESHOLD:  cfg_thr        = val[30:0];
      bpqsf_pkg::REG_MIN_CONSEC: cfg_min_consec = val[15:0];
      bpqsf_pkg::REG_PAD:        cfg_pad        = val[15:0];
      bpqsf_pkg::REG_MIN_QUIET:  cfg_min_quiet  = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic logic [bpqsf_pkg::IDX_W-1:0] block_to_index(longint blk);
    longint v;
    if (blk <= 0) return '0;
    v = blk * ((cfg_len == 0) ? 64'sd1 : longint'(cfg_len));
    if (v > 64'sd4294967295) return 32'hFFFF_FFFF;
    return v[31:0];
  endfunction

  // queue the stretch [b0, b1) in blocks if it is long enough
  function automatic bit push_span(longint b0, longint b1);
    span_t  sp;
    longint e;
    if (b1 - b0 < longint'(cfg_min_quiet)) return 1'b0;
    e = (b1 < longint'(blk_count)) ? b1 : longint'(blk_count);
    sp.start_sample = block_to_index(b0);
    sp.end_sample   = block_to_index(e);
    pending_spans.push_back(sp);
    return 1'b1;
  endfunction

  function automatic bit close_block();
    longint unsigned cnt, mag, lhs, s2, diff, bar;
    longint          idx;
    bit              loud;
    bit              got;
    cnt  = 64'(blk_fill);
    mag  = (blk_sum < 0) ? -blk_sum : blk_sum;
    lhs  = cnt * blk_energy;
    s2   = mag * mag;
    diff = (lhs >= s2) ? lhs - s2 : 64'd0;
    bar  = 64'(cfg_thr) * cnt * cnt;
    loud = (diff >= bar);
    idx  = longint'(blk_count);
    got  = 1'b0;
    blk_fill   = 0;
    blk_sum    = 0;
    blk_energy = 0;
    if (blk_count != 32'hFFFF_FFFF) blk_count++;
    if (loud) begin
      if (loud_len != 32'hFFFF_FFFF) loud_len++;
      if (loud_len == 32'(cfg_min_consec) && !noisy) begin
        noisy = 1'b1;
        got = push_span(quiet_from,
                        idx - longint'(loud_len) + 1 - longint'(cfg_pad));
      end
    end else begin
      if (noisy) quiet_from = idx + longint'(cfg_pad);
      loud_len = 0;
      noisy    = 1'b0;
    end
    return got;
  endfunction

  function automatic void track_sample(logic signed [bpqsf_pkg::SAMPLE_W-1:0] s,
                                       bit is_last);
    longint          sv;
    longint unsigned m;
    longint          tail;
    int unsigned     eff_len;
    bit              got;
    sv      = longint'(s);
    m       = (sv < 0) ? -sv : sv;
    eff_len = (cfg_len == 0) ? 32'd1 : 32'(cfg_len);
    got     = 1'b0;
    blk_sum    += sv;
    blk_energy += m * m;
    blk_fill++;
    if (blk_fill >= eff_len) got = close_block();
    if (is_last) begin
      // trailing stretch, cut short by a loud run that never became noise
      if (!noisy && !got) begin
        tail = longint'(blk_count);
        if (loud_len != 0) tail = tail - longint'(loud_len) - longint'(cfg_pad);
        got = push_span(quiet_from, tail);
      end
      clear_tracking();
    end
  endfunction

  task automatic send_sample(logic signed [bpqsf_pkg::SAMPLE_W-1:0] s, bit is_last);
    int gap;
    gap = int'($urandom_range(0, tx_gap_max));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.last   <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_sample(s, is_last);
    n_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it after its last write
  task automatic put_reg(logic [bpqsf_pkg::CFG_IDX_W-1:0] idx,
                         logic [bpqsf_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic set_config(logic [15:0] len, logic [30:0] thr, logic [15:0] consec,
                            logic [15:0] pad, logic [15:0] min_quiet);
    wait_idle();
    put_reg(bpqsf_pkg::REG_BLOCK_LEN, 31'(len));
    put_reg(bpqsf_pkg::REG_THRESHOLD, thr);
    put_reg(bpqsf_pkg::REG_MIN_CONSEC, 31'(consec));
    put_reg(bpqsf_pkg::REG_PAD, 31'(pad));
    put_reg(bpqsf_pkg::REG_MIN_QUIET, 31'(min_quiet));
    cfg_we <= 1'b0;
  endtask

  // runs of quiet blocks (dc plus small jitter) and loud blocks (full range noise)
  task automatic send_signal(int total, bit noise);
    int          k, run_left, dc, eff_len;
    bit          loud;
    logic [15:0] s;
    eff_len  = (cfg_len == 0) ? 1 : int'(cfg_len);
    loud     = 1'($urandom_range(0, 1));
    run_left = 0;
    dc       = 0;
    for (k = 0; k < total; k++) begin
      if (k % eff_len == 0) begin
        if (run_left == 0) begin
          loud     = !loud;
          run_left = int'($urandom_range(1, 4));
        end
        run_left--;
        dc = int'($urandom_range(0, 64000)) - 32000;
      end
      if (noise || loud) begin
        s = 16'($urandom);
      end else begin
        s = 16'(dc + int'($urandom_range(0, 3)));
      end
      send_sample(s, k == total - 1);
    end
  endtask

  task automatic test_reset_values();
    // only the block length moves off its default; unused index must be ignored
    put_reg(bpqsf_pkg::REG_BLOCK_LEN, 31'd2);
    put_reg(REG_UNUSED, 31'($urandom));
    cfg_we <= 1'b0;
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    set_config(16'd2, 31'h7FFF_FFFF, 16'd1, 16'd0, 16'd1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b1);
    // zero threshold makes every block loud
    set_config(16'd2, 31'd0, 16'd1, 16'd0, 16'd0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd9, 1'b1);
  endtask

  task automatic test_zero_block_len();
    set_config(16'd0, 31'd0, 16'd2, 16'd1, 16'd0);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd7, 1'b1);
  endtask

  task automatic test_shrink_block_len();
    set_config(16'd4, 31'd100, 16'd1, 16'd0, 16'd0);
    send_sample(16'sd3000, 1'b0);
    send_sample(-16'sd3000, 1'b0);
    send_sample(16'sd3000, 1'b0);
    // the partly filled block closes on the next item
    set_config(16'd2, 31'd100, 16'd1, 16'd0, 16'd0);
    send_sample(-16'sd3000, 1'b0);
    send_sample(16'sd10, 1'b0);
    send_sample(16'sd10, 1'b1);
  endtask

  task automatic test_partial_block();
    set_config(16'd3, 31'd100, 16'd1, 16'd1, 16'd1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd20000, 1'b1);
  endtask

  task automatic test_zero_consec();
    set_config(16'd1, 31'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
  endtask

  task automatic test_random_signals();
    int          goal, r, n_sig, eff_len, total;
    logic [15:0] len, consec, pad, min_quiet;
    logic [30:0] thr;
    goal = n_sent + 1400;
    while (n_sent < goal) begin
      r   = int'($urandom_range(0, 9));
      len = (r < 7) ? 16'($urandom_range(2, 6))
                    : (r < 8) ? 16'($urandom_range(0, 1)) : 16'($urandom_range(7, 40));
      r   = int'($urandom_range(0, 9));
      thr = (r < 8) ? 31'($urandom_range(16, 4000)) : (r == 8) ? 31'd0 : 31'($urandom);
      consec    = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4));
      pad       = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom_range(0, 3));
      min_quiet = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4));
      set_config(len, thr, consec, pad, min_quiet);
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
      rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
      eff_len = (len == 0) ? 1 : int'(len);
      n_sig   = int'($urandom_range(1, 4));
      repeat (n_sig) begin
        r = int'($urandom_range(0, 9));
        if (r < 2) begin
          send_signal(int'($urandom_range(1, 3 * eff_len + 2)), 1'b1);
        end else begin
          total = int'($urandom_range(1, 12)) * eff_len;
          // some signals end inside a block
          if (r < 5 && eff_len > 1) total += int'($urandom_range(1, eff_len - 1));
          send_signal(total, 1'b0);
        end
      end
    end
    tx_gap_max = 5;
    rx_gap_max = 5;
  endtask

  task automatic test_output_stall();
    set_config(16'd2, 31'd100, 16'd1, 16'd0, 16'd0);
    tx_gap_max     = 0;
    rx_hold_cycles = 400;
    send_signal(320, 1'b0);
    tx_gap_max = 5;
  endtask

  task automatic test_longest_block();
    int k;
    set_config(16'd256, 31'h3FFF_0000, 16'd1, 16'd0, 16'd0);
    tx_gap_max = 0;
    for (k = 0; k < 256; k++) begin
      send_sample((k % 2 == 0) ? 16'sh7FFF : 16'sh8000, k == 255);
    end
    tx_gap_max = 5;
  endtask

  // result side: random stalls per item, plus a long hold on request
  initial begin : span_sink
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      n = int'($urandom_range(0, rx_gap_max));
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid && rx_hold_cycles == 0) @(posedge clk);
    end
  end

  always @(posedge clk) begin : span_check
    span_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_spans.size() == 0) begin
        $error("unexpected span start_sample=%0d end_sample=%0d",
               out_ch.start_sample, out_ch.end_sample);
        n_err++;
      end else begin
        want = pending_spans.pop_front();
        if (out_ch.start_sample !== want.start_sample) begin
          $error("start_sample: expected %0d, got %0d", want.start_sample,
                 out_ch.start_sample);
          n_err++;
        end
        if (out_ch.end_sample !== want.end_sample) begin
          $error("end_sample: expected %0d, got %0d", want.end_sample, out_ch.end_sample);
          n_err++;
        end
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("FAIL block_power_quiet_span_finder_unit");
    $finish;
  end

  initial begin : run_tests
    n_err          = 0;
    n_sent         = 0;
    tx_gap_max     = 5;
    rx_gap_max     = 5;
    rx_hold_cycles = 0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= bpqsf_pkg::REG_BLOCK_LEN;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.sample   <= '0;
    in_ch.last     <= 1'b0;
    cfg_len        = bpqsf_pkg::BLOCK_LEN_RST;
    cfg_thr        = bpqsf_pkg::THRESHOLD_RST;
    cfg_min_consec = bpqsf_pkg::MIN_CONSEC_RST;
    cfg_pad        = bpqsf_pkg::PAD_RST;
    cfg_min_quiet  = bpqsf_pkg::MIN_QUIET_RST;
    clear_tracking();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_threshold_extremes();
    test_zero_block_len();
    test_shrink_block_len();
    test_partial_block();
    test_zero_consec();
    test_random_signals();
    test_output_stall();
    test_longest_block();

    wait_idle();
    if (n_err == 0) begin
      $display("PASS block_power_quiet_span_finder_unit");
    end else begin
      $display("FAIL block_power_quiet_span_finder_unit");
    end
    $finish;
  end

endmodule
